@@ hw/rtl/snas_pkg.sv @@
// Shared types, constants and helpers for the spiking neuron array step core.
package snas_pkg;

  localparam int NEURON_COUNT_DEF  = 64;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int OPCODE_W    = 2;
  localparam int NEURON_W    = 6;
  localparam int CURRENT_W   = 16;
  localparam int STATE_W     = 32;
  localparam int MASK_W      = 64;
  localparam int ACTIVE_W    = 7;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int DIV_W       = 64;
  localparam int DIVISOR_W   = 8;

  localparam logic [OPCODE_W-1:0] OP_DELIVER = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_EXC_MASK     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_COUNT = 4'd1;

  localparam logic [DIVISOR_W-1:0] DSR_QUAD = 8'd25;
  localparam logic [DIVISOR_W-1:0] DSR_RS   = 8'd250;
  localparam logic [DIVISOR_W-1:0] DSR_FS   = 8'd50;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {WR_NONE, WR_DELIVER, WR_FIRE, WR_UPDATE} wr_kind_t;
  typedef enum logic {DIV_QUAD, DIV_RECOVERY} div_sel_t;

  typedef struct packed {
    logic signed [STATE_W-1:0] v;
    logic signed [STATE_W-1:0] u;
    logic signed [STATE_W-1:0] acc;
  } nrn_t;

  typedef struct packed {
    logic     in_take;
    logic     clr_all;
    logic     rd_en;
    logic     addr_tgt;
    wr_kind_t wr_kind;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     mul_en;
    logic     div_start;
    div_sel_t div_sel;
    logic     nv_en;
    logic     fire_push;
    logic     fin_push;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_fire;
    logic pend_valid;
    logic out_free;
    logic div_busy;
    logic cnt_last;
    logic lim_zero;
    logic tgt_ok;
  } ctl_stat_t;

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [STATE_W-1:0] r;
    if (x > S32_MAX) begin
      r = S32_MAX[STATE_W-1:0];
    end else if (x < S32_MIN) begin
      r = S32_MIN[STATE_W-1:0];
    end else begin
      r = x[STATE_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/snas_req_if.sv @@
// Request channel: opcode, target neuron and input current.
interface snas_req_if;
  import snas_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [OPCODE_W-1:0]         opcode;
  logic [NEURON_W-1:0]         target_neuron;
  logic signed [CURRENT_W-1:0] current_amount;
  modport source (output valid, opcode, target_neuron, current_amount, input ready);
  modport sink   (input valid, opcode, target_neuron, current_amount, output ready);
endinterface

@@ hw/rtl/snas_rsp_if.sv @@
// Result channel: firing reports of a tick.
interface snas_rsp_if;
  import snas_pkg::*;
  logic                valid;
  logic                ready;
  logic [NEURON_W-1:0] fired_neuron;
  logic                fired_valid;
  logic                last_of_tick;
  modport source (output valid, fired_neuron, fired_valid, last_of_tick, input ready);
  modport sink   (input valid, fired_neuron, fired_valid, last_of_tick, output ready);
endinterface

@@ hw/rtl/snas_cfg_if.sv @@
// Configuration write channel.
interface snas_cfg_if;
  import snas_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/snas_div.sv @@
// Iterative unsigned divider by a small divisor, eight quotient bits per cycle.
module snas_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [snas_pkg::DIV_W-1:0]     dividend,
  input  logic [snas_pkg::DIVISOR_W-1:0] divisor,
  output logic                           busy,
  output logic [snas_pkg::DIV_W-1:0]     quotient
);
  import snas_pkg::*;

  localparam int STEP_BITS = 8;
  localparam int ROUNDS    = DIV_W / STEP_BITS;
  localparam int RND_W     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  logic [DIV_W-1:0]     work;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [RND_W-1:0]     rnd;
  logic [DIV_W-1:0]     work_next;
  logic [DIVISOR_W-1:0] rem_next;
  logic [DIVISOR_W:0]   r2;

  always_comb begin
    work_next = work;
    rem_next  = rem;
    r2        = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      r2        = {rem_next, work_next[DIV_W-1]};
      work_next = {work_next[DIV_W-2:0], 1'b0};
      if (r2 >= {1'b0, dsr}) begin
        r2           = r2 - {1'b0, dsr};
        work_next[0] = 1'b1;
      end
      rem_next = r2[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      rnd  <= '0;
    end else if (busy) begin
      rnd <= rnd + RND_W'(1);
      if (rnd == RND_W'(ROUNDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient = work;

endmodule

@@ hw/rtl/snas_datapath.sv @@
// Neuron state memory, arithmetic, configuration registers and result register.
module snas_datapath #(
  parameter int NEURON_COUNT  = snas_pkg::NEURON_COUNT_DEF,
  parameter int FRACTION_BITS = snas_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  snas_pkg::ctl_cmd_t                  cmd,
  output snas_pkg::ctl_stat_t                 stat,
  input  logic                                cfg_we,
  input  logic [snas_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [snas_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [snas_pkg::NEURON_W-1:0]       target_neuron,
  input  logic signed [snas_pkg::CURRENT_W-1:0] current_amount,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [snas_pkg::NEURON_W-1:0]       fired_neuron,
  output logic                                fired_valid,
  output logic                                last_of_tick
);
  import snas_pkg::*;

  localparam int AW     = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
  localparam int AMT_SH = FRACTION_BITS - 8;
  localparam int S1_W   = 40;

  localparam logic signed [63:0] V_RESET_W = -64'sd65 <<< FRACTION_BITS;
  localparam logic signed [63:0] U_RESET_W = -64'sd13 <<< FRACTION_BITS;
  localparam logic signed [63:0] V_PEAK_W  = 64'sd30 <<< FRACTION_BITS;
  localparam logic signed [63:0] C140      = 64'sd140 <<< FRACTION_BITS;
  localparam logic signed [63:0] D_RS      = 64'sd8 <<< FRACTION_BITS;
  localparam logic signed [63:0] D_FS      = 64'sd2 <<< FRACTION_BITS;
  localparam logic signed [STATE_W-1:0] V_RESET = V_RESET_W[STATE_W-1:0];
  localparam logic signed [STATE_W-1:0] U_RESET = U_RESET_W[STATE_W-1:0];
  localparam logic signed [STATE_W-1:0] V_PEAK  = V_PEAK_W[STATE_W-1:0];
  localparam logic [ACTIVE_W-1:0] ACT_N = ACTIVE_W'(NEURON_COUNT);

  logic [MASK_W-1:0]   exc_mask;
  logic [ACTIVE_W-1:0] active_count;
  logic [ACTIVE_W-1:0] lim;

  logic [NEURON_W-1:0]         tgt_r;
  logic signed [CURRENT_W-1:0] amt_r;

  logic [AW-1:0] j;
  logic [AW-1:0] addr;

  nrn_t              mem [NEURON_COUNT];
  logic [NEURON_COUNT-1:0] vld;
  nrn_t              rd_q;
  logic              rd_vld;
  nrn_t              cur;
  nrn_t              wdata;
  logic              wen;

  logic signed [63:0] v64, u64, a64, amt64;
  logic signed [STATE_W-1:0] vs;
  logic signed [63:0] sq;
  logic signed [S1_W-1:0] s1;
  logic signed [63:0] s1_w;
  logic signed [STATE_W-1:0] v32;
  logic signed [63:0] xw;
  logic               x_neg;
  logic signed [63:0] du;
  logic signed [STATE_W-1:0] u_fire, u_upd, acc_add;
  logic               exc;

  logic [DIV_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic                 div_busy;
  logic [DIV_W-1:0]     quot;

  logic [AW-1:0] pend_j;
  logic          pend_valid;
  logic          push;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      exc_mask     <= '0;
      active_count <= ACTIVE_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXC_MASK:     exc_mask     <= cfg_data[MASK_W-1:0];
        CFG_ACTIVE_COUNT: active_count <= cfg_data[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  assign lim = (active_count > ACT_N) ? ACT_N : active_count;

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      tgt_r <= target_neuron;
      amt_r <= current_amount;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) begin
      j <= '0;
    end else if (cmd.cnt_inc) begin
      j <= j + AW'(1);
    end
  end

  assign addr = cmd.addr_tgt ? tgt_r[AW-1:0] : j;
  assign exc  = exc_mask[j];

  // state memory; an entry without its valid bit reads as the reset state
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q <= mem[addr];
    end
    if (wen) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_all) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        rd_vld <= vld[addr];
      end
      if (wen) begin
        vld[addr] <= 1'b1;
      end
    end
  end

  always_comb begin
    if (rd_vld) begin
      cur = rd_q;
    end else begin
      cur.v   = V_RESET;
      cur.u   = U_RESET;
      cur.acc = '0;
    end
  end

  assign v64   = {{32{cur.v[STATE_W-1]}}, cur.v};
  assign u64   = {{32{cur.u[STATE_W-1]}}, cur.u};
  assign a64   = {{32{cur.acc[STATE_W-1]}}, cur.acc};
  assign amt64 = {{(64-CURRENT_W){amt_r[CURRENT_W-1]}}, amt_r} <<< AMT_SH;
  assign vs    = cur.v;

  assign acc_add = sat32(a64 + amt64);
  assign u_fire  = sat32(u64 + (exc ? D_RS : D_FS));

  // v^2 and the linear part of the membrane update
  assign s1_w = 64'sd6 * v64 + C140 - u64 + a64;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      sq <= vs * vs;
      s1 <= s1_w[S1_W-1:0];
    end
    if (cmd.nv_en) begin
      v32 <= sat32({{(64-S1_W){s1[S1_W-1]}}, s1} + $signed(quot));
    end
  end

  // floor((v' - 5u) / D) taken as ~(~x / D) for negative x
  assign xw    = {{32{v32[STATE_W-1]}}, v32} - 64'sd5 * u64;
  assign x_neg = xw[63];
  assign du    = x_neg ? $signed(~quot) : $signed(quot);
  assign u_upd = sat32(u64 + du);

  always_comb begin
    if (cmd.div_sel == DIV_QUAD) begin
      div_dividend = DIV_W'(sq) >> FRACTION_BITS;
      div_divisor  = DSR_QUAD;
    end else begin
      div_dividend = x_neg ? ~xw : xw;
      div_divisor  = exc ? DSR_RS : DSR_FS;
    end
  end

  snas_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quot)
  );

  always_comb begin
    wen   = 1'b1;
    wdata = cur;
    case (cmd.wr_kind)
      WR_DELIVER: wdata.acc = acc_add;
      WR_FIRE: begin
        wdata.v = V_RESET;
        wdata.u = u_fire;
      end
      WR_UPDATE: begin
        wdata.v   = v32;
        wdata.u   = u_upd;
        wdata.acc = '0;
      end
      WR_NONE: wen = 1'b0;
      default: wen = 1'b0;
    endcase
  end

  // pending firing and result register
  assign push = (cmd.fire_push && pend_valid) || cmd.fin_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.fin_push) begin
        pend_valid <= 1'b0;
      end else if (cmd.fire_push) begin
        pend_valid <= 1'b1;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire_push) begin
      pend_j <= j;
    end
    if (cmd.fin_push) begin
      fired_neuron <= pend_valid ? NEURON_W'(pend_j) : '0;
      fired_valid  <= pend_valid;
      last_of_tick <= 1'b1;
    end else if (push) begin
      fired_neuron <= NEURON_W'(pend_j);
      fired_valid  <= 1'b1;
      last_of_tick <= 1'b0;
    end
  end

  assign stat.is_fire    = cur.v >= V_PEAK;
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.div_busy   = div_busy;
  assign stat.cnt_last   = (ACTIVE_W'(j) + ACTIVE_W'(1)) >= lim;
  assign stat.lim_zero   = lim == '0;
  assign stat.tgt_ok     = {1'b0, tgt_r} < ACTIVE_W'(NEURON_COUNT);

endmodule

@@ hw/rtl/snas_ctrl.sv @@
// Sequencer for deliver, tick and clear items.
module snas_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic [snas_pkg::OPCODE_W-1:0] req_opcode,
  output logic                          req_ready,
  output snas_pkg::ctl_cmd_t            cmd,
  input  snas_pkg::ctl_stat_t           stat
);
  import snas_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_D_RD, S_D_WR, S_T_FRD, S_T_FCHK, S_T_FIN, S_T_URD, S_T_MUL,
    S_T_QST, S_T_QWT, S_T_NV, S_T_XST, S_T_UWT, S_T_UWR
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.cnt_clr = 1'b1;
        if (req_valid) begin
          cmd.in_take = 1'b1;
          case (req_opcode)
            OP_DELIVER: state_next = S_D_RD;
            OP_TICK:    state_next = stat.lim_zero ? S_T_FIN : S_T_FRD;
            OP_CLEAR:   cmd.clr_all = 1'b1;
            default: ;
          endcase
        end
      end
      S_D_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_tgt = 1'b1;
        state_next   = S_D_WR;
      end
      S_D_WR: begin
        cmd.addr_tgt = 1'b1;
        if (stat.tgt_ok) begin
          cmd.wr_kind = WR_DELIVER;
        end
        state_next = S_IDLE;
      end
      S_T_FRD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_T_FCHK;
      end
      S_T_FCHK: begin
        if (!(stat.is_fire && stat.pend_valid && !stat.out_free)) begin
          if (stat.is_fire) begin
            cmd.wr_kind   = WR_FIRE;
            cmd.fire_push = 1'b1;
          end
          if (stat.cnt_last) begin
            state_next = S_T_FIN;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next  = S_T_FRD;
          end
        end
      end
      S_T_FIN: begin
        if (stat.out_free) begin
          cmd.fin_push = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_next   = stat.lim_zero ? S_IDLE : S_T_URD;
        end
      end
      S_T_URD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_T_MUL;
      end
      S_T_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_T_QST;
      end
      S_T_QST: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_QUAD;
        state_next    = S_T_QWT;
      end
      S_T_QWT: begin
        if (!stat.div_busy) begin
          state_next = S_T_NV;
        end
      end
      S_T_NV: begin
        cmd.nv_en  = 1'b1;
        state_next = S_T_XST;
      end
      S_T_XST: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RECOVERY;
        state_next    = S_T_UWT;
      end
      S_T_UWT: begin
        cmd.div_sel = DIV_RECOVERY;
        if (!stat.div_busy) begin
          state_next = S_T_UWR;
        end
      end
      S_T_UWR: begin
        cmd.div_sel = DIV_RECOVERY;
        cmd.wr_kind = WR_UPDATE;
        if (stat.cnt_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = S_T_URD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/spiking_neuron_array_step_core.sv @@
// Top level of the Izhikevich neuron array step core.
//
// Channels: req carries deliver, tick and clear items; rsp carries firing
// reports; cfg writes excitatory_mask (index 0) and active_count (index 1)
// and is always ready. Configuration must be written only while no item is
// in work; the block itself does not enforce this. A clear beat resets all
// neuron state at once through per-entry valid bits.
// A tick walks the active neurons twice. The fire pass reads and checks
// each neuron and reports firings in ascending order; one report is held
// back so the final one carries last_of_tick, and a tick with no firing
// reports a single beat with fired_valid low. The update pass reads each
// neuron, squares v in the shared 32x32 multiplier and runs the divider unit,
// which yields 8 quotient bits a cycle, twice per neuron (v^2/25 and the
// recovery term), then writes the neuron back.
// req.ready is high only between items. Reports sit in one output register;
// when the receiver stalls, the fire pass waits at the next firing.
// Reset (rst, synchronous) clears the neuron state and any held report and
// sets the configuration to a zero mask and active_count 64.
module spiking_neuron_array_step_core #(
  parameter int NEURON_COUNT  = snas_pkg::NEURON_COUNT_DEF,
  parameter int FRACTION_BITS = snas_pkg::FRACTION_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  snas_req_if.sink   req,
  snas_rsp_if.source rsp,
  snas_cfg_if.sink   cfg
);
  import snas_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  assign cfg.ready = 1'b1;

  snas_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  snas_datapath #(
    .NEURON_COUNT  (NEURON_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .target_neuron  (req.target_neuron),
    .current_amount (req.current_amount),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .fired_neuron   (rsp.fired_neuron),
    .fired_valid    (rsp.fired_valid),
    .last_of_tick   (rsp.last_of_tick)
  );

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ((cmd.fire_push && stat.pend_valid) || cmd.fin_push) |-> stat.out_free)
    else $error("result pushed over an untaken beat");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider restarted while busy");

  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_push |=> (rsp.valid && rsp.last_of_tick))
    else $error("closing beat of a tick not presented as last");

  a_nofire_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.fired_valid) |-> rsp.last_of_tick)
    else $error("no-firing beat not marked last");
`endif

endmodule

@@ tb/spiking_neuron_array_step_core_test.sv @@
`timescale 1ns / 100ps
// Testbench for spiking_neuron_array_step_core: directed and random beats against a predictor.
module spiking_neuron_array_step_core_test;
  import snas_pkg::*;

  localparam int     PERIOD          = 10;
  localparam int     NEURONS         = NEURON_COUNT_DEF;
  localparam int     FRAC            = FRACTION_BITS_DEF;
  localparam longint ONE             = 64'sd1 <<< FRAC;
  localparam longint FIRE_LEVEL      = 30 * ONE;
  localparam longint V_REST          = -65 * ONE;
  localparam longint U_REST          = -13 * ONE;
  localparam longint D_RS            = 8 * ONE;
  localparam longint D_FS            = 2 * ONE;
  localparam longint DRIVE_140       = 140 * ONE;
  localparam longint QUAD_DIV        = 25 * ONE;
  localparam longint RS_RECOVERY_DIV = 250;
  localparam longint FS_RECOVERY_DIV = 50;
  localparam longint CURRENT_SCALE   = 64'sd1 <<< (FRAC - 8);
  localparam longint Q_MAX           = 64'sd2147483647;
  localparam longint Q_MIN           = -64'sd2147483648;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int     SETTLE_CYCLES   = 2000;
  localparam int     RX_HOLD_CYCLES  = 3000;
  localparam int     CYCLE_LIMIT     = 2000000;

  typedef struct packed {
    logic [OPCODE_W-1:0]         opcode;
    logic [NEURON_W-1:0]         target;
    logic signed [CURRENT_W-1:0] amount;
  } req_beat_t;

  typedef struct packed {
    logic [NEURON_W-1:0] neuron;
    logic                fired;
    logic                last;
  } fire_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  snas_req_if req_bus ();
  snas_rsp_if rsp_bus ();
  snas_cfg_if cfg_bus ();

  spiking_neuron_array_step_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  req_beat_t beat_q[$];
  fire_rec_t fire_q[$];
  req_beat_t next_beat;
  logic      req_took   = 1'b0;
  logic      rx_hold    = 1'b0;
  logic      rx_hold_go = 1'b0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        beats_queued = 0;
  int        beats_taken  = 0;
  int        errors       = 0;
  int        cycle_count  = 0;

  logic signed [STATE_W-1:0] shadow_v   [NEURONS];
  logic signed [STATE_W-1:0] shadow_u   [NEURONS];
  logic signed [STATE_W-1:0] shadow_acc [NEURONS];
  logic [MASK_W-1:0]         shadow_mask;
  logic [ACTIVE_W-1:0]       shadow_active;

  always #(PERIOD / 2) clk = ~clk;

  function automatic logic signed [STATE_W-1:0] clamp32(input longint x);
    if (x > Q_MAX) return Q_MAX[STATE_W-1:0];
    if (x < Q_MIN) return Q_MIN[STATE_W-1:0];
    return x[STATE_W-1:0];
  endfunction

  function automatic longint floor_div(input longint num, input longint den);
    longint q;
    q = num / den;
    if (num < 0 && (num % den) != 0) q = q - 1;
    return q;
  endfunction

  task automatic reset_neurons();
    for (int j = 0; j < NEURONS; j++) begin
      shadow_v[j]   = clamp32(V_REST);
      shadow_u[j]   = clamp32(U_REST);
      shadow_acc[j] = '0;
    end
  endtask

  task automatic add_current(input logic [NEURON_W-1:0] tgt,
                             input logic signed [CURRENT_W-1:0] amt);
    if (int'(tgt) < NEURONS)
      shadow_acc[tgt] = clamp32(longint'(shadow_acc[tgt]) + longint'(amt) * CURRENT_SCALE);
  endtask

  // fire pass first (ascending), then the membrane/recovery update over the same span
  task automatic run_tick();
    int        span;
    int        fired_n;
    longint    v;
    longint    u;
    longint    quad;
    longint    nv;
    longint    du;
    fire_rec_t rec;
    logic signed [STATE_W-1:0] v_new;
    span = (shadow_active > NEURONS) ? NEURONS : int'(shadow_active);
    fired_n = 0;
    for (int j = 0; j < span; j++) begin
      if (longint'(shadow_v[j]) >= FIRE_LEVEL) begin
        shadow_v[j] = clamp32(V_REST);
        shadow_u[j] = clamp32(longint'(shadow_u[j]) + (shadow_mask[j] ? D_RS : D_FS));
        fire_q.insert(fire_q.size(), fire_rec_t'{NEURON_W'(j), 1'b1, 1'b0});
        fired_n++;
      end
    end
    for (int j = 0; j < span; j++) begin
      v = shadow_v[j];
      u = shadow_u[j];
      quad = (v * v) / QUAD_DIV;
      nv = v + quad + 5 * v + DRIVE_140 - u + longint'(shadow_acc[j]);
      v_new = clamp32(nv);
      du = floor_div(longint'(v_new) - 5 * u,
                     shadow_mask[j] ? RS_RECOVERY_DIV : FS_RECOVERY_DIV);
      shadow_v[j]   = v_new;
      shadow_u[j]   = clamp32(u + du);
      shadow_acc[j] = '0;
    end
    if (fired_n == 0) begin
      fire_q.insert(fire_q.size(), fire_rec_t'{'0, 1'b0, 1'b1});
    end else begin
      rec = fire_q[fire_q.size() - 1];
      rec.last = 1'b1;
      fire_q[fire_q.size() - 1] = rec;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic check_report(input logic [NEURON_W-1:0] nrn, input logic fv, input logic lst);
    fire_rec_t want;
    if (fire_q.size() == 0) begin
      report_mismatch($sformatf("unexpected beat neuron %0d fired_valid %0b last %0b",
                                nrn, fv, lst));
    end else begin
      want = fire_q[0];
      fire_q.delete(0);
      if (nrn !== want.neuron)
        report_mismatch($sformatf("fired_neuron %0d, want %0d", nrn, want.neuron));
      if (fv !== want.fired)
        report_mismatch($sformatf("fired_valid %0b, want %0b (neuron %0d)",
                                  fv, want.fired, want.neuron));
      if (lst !== want.last)
        report_mismatch($sformatf("last_of_tick %0b, want %0b (neuron %0d)",
                                  lst, want.last, want.neuron));
    end
  endtask

  // monitor: checks result beats, then applies accepted config and request beats
  always @(posedge clk) begin
    if (rst) begin
      req_took <= 1'b0;
      shadow_mask = '0;
      shadow_active = ACTIVE_W'(64);
      reset_neurons();
    end else begin
      req_took <= req_bus.valid && req_bus.ready;
      if (rsp_bus.valid && rsp_bus.ready)
        check_report(rsp_bus.fired_neuron, rsp_bus.fired_valid, rsp_bus.last_of_tick);
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          CFG_EXC_MASK:     shadow_mask = cfg_bus.data;
          CFG_ACTIVE_COUNT: shadow_active = cfg_bus.data[ACTIVE_W-1:0];
          default: ;
        endcase
      end
      if (req_bus.valid && req_bus.ready) begin
        beats_taken++;
        case (req_bus.opcode)
          OP_DELIVER: add_current(req_bus.target_neuron, req_bus.current_amount);
          OP_TICK:    run_tick();
          OP_CLEAR:   reset_neurons();
          default: ;
        endcase
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_took) begin
      if (beat_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_beat = beat_q[0];
        beat_q.delete(0);
        req_bus.valid          <= 1'b1;
        req_bus.opcode         <= next_beat.opcode;
        req_bus.target_neuron  <= next_beat.target;
        req_bus.current_amount <= next_beat.amount;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) rsp_bus.ready <= 1'b0;
    else rsp_bus.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // long receiver stall while the sender keeps offering beats
  always begin
    wait (rx_hold_go);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
    wait (!rx_hold_go);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("spiking_neuron_array_step_core verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic queue_beat(input logic [OPCODE_W-1:0] op, input logic [NEURON_W-1:0] tgt,
                            input logic signed [CURRENT_W-1:0] amt);
    beat_q.insert(beat_q.size(), req_beat_t'{op, tgt, amt});
    beats_queued++;
  endtask

  // mostly positive drive so neurons reach threshold, some full-range values
  function automatic logic signed [CURRENT_W-1:0] pick_current();
    if ($urandom_range(99) < 75) return CURRENT_W'($urandom_range(32767, 1024));
    return CURRENT_W'($urandom);
  endfunction

  task automatic queue_traffic(input int n_items, input int span);
    int made;
    int burst;
    int roll;
    made = 0;
    while (made < n_items) begin
      roll = $urandom_range(99);
      if (roll < 72) begin
        burst = $urandom_range(6, 1);
        repeat (burst)
          queue_beat(OP_DELIVER, NEURON_W'($urandom_range(span - 1)), pick_current());
        queue_beat(OP_TICK, NEURON_W'($urandom), CURRENT_W'($urandom));
        made += burst + 1;
      end else if (roll < 84) begin
        queue_beat(OP_DELIVER, NEURON_W'($urandom_range(NEURONS - 1)), CURRENT_W'($urandom));
        made++;
      end else if (roll < 88) begin
        queue_beat(OP_CLEAR, NEURON_W'($urandom), CURRENT_W'($urandom));
        made++;
      end else if (roll < 93) begin
        queue_beat(OP_UNUSED, NEURON_W'($urandom), CURRENT_W'($urandom));
      end else begin
        queue_beat(OP_TICK, NEURON_W'($urandom), CURRENT_W'($urandom));
        made++;
      end
    end
  endtask

  // the update pass runs on after the last report, so allow a full tick before moving on
  task automatic wait_drained();
    while (!(beats_taken == beats_queued && beat_q.size() == 0 && fire_q.size() == 0))
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    req_bus.valid          = 1'b0;
    req_bus.opcode         = OP_DELIVER;
    req_bus.target_neuron  = '0;
    req_bus.current_amount = '0;
    rsp_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = CFG_EXC_MASK;
    cfg_bus.data           = '0;
    tx_idle_pct = 17;
    rx_idle_pct = 48;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(CFG_EXC_MASK, '0);
    write_reg(CFG_ACTIVE_COUNT, CFG_DATA_W'(64));
    queue_beat(OP_TICK, '0, '0);
    queue_beat(OP_DELIVER, 6'd0, 16'sh7fff);
    queue_beat(OP_DELIVER, 6'd63, 16'sh7fff);
    queue_beat(OP_DELIVER, 6'd5, 16'sh8000);
    queue_beat(OP_DELIVER, 6'd9, 16'sh0001);
    queue_beat(OP_DELIVER, 6'd9, 16'shffff);
    queue_beat(OP_UNUSED, 6'd42, 16'sh5555);
    queue_beat(OP_TICK, 6'h3f, 16'shffff);
    queue_beat(OP_TICK, '0, '0);
    queue_beat(OP_TICK, '0, '0);
    queue_beat(OP_DELIVER, 6'd10, 16'sh7fff);
    queue_beat(OP_DELIVER, 6'd10, 16'sh7fff);
    queue_beat(OP_DELIVER, 6'h2a, 16'sh2aaa);
    queue_beat(OP_DELIVER, 6'h15, 16'shd555);
    queue_beat(OP_CLEAR, '0, '0);
    queue_beat(OP_TICK, '0, '0);
    queue_beat(OP_DELIVER, 6'd10, 16'sh7fff);
    queue_beat(OP_TICK, '0, '0);
    queue_beat(OP_TICK, '0, '0);
    wait_drained();

    write_reg(CFG_EXC_MASK, {$urandom, $urandom});
    write_reg(CFG_ACTIVE_COUNT, CFG_DATA_W'(8));
    rx_hold_go = 1'b1;
    queue_traffic(120, 8);
    wait_drained();
    rx_hold_go = 1'b0;

    tx_idle_pct = 48;
    rx_idle_pct = 17;
    write_reg(CFG_EXC_MASK, '1);
    write_reg(CFG_ACTIVE_COUNT, CFG_DATA_W'(1));
    queue_traffic(50, 1);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_EXC_MASK, '0);
    write_reg(CFG_ACTIVE_COUNT, CFG_DATA_W'(127));
    queue_traffic(30, NEURONS);
    wait_drained();

    write_reg(CFG_EXC_MASK, {$urandom, $urandom});
    write_reg(CFG_ACTIVE_COUNT, '0);
    queue_traffic(20, NEURONS);
    wait_drained();

    write_reg(CFG_EXC_MASK, {$urandom, $urandom});
    write_reg(CFG_ACTIVE_COUNT, CFG_DATA_W'($urandom_range(16, 2)));
    queue_traffic(60, 16);
    wait_drained();
    queue_traffic(60, 16);
    wait_drained();

    if (errors == 0) begin
      $display("spiking_neuron_array_step_core verification clean");
    end else begin
      $display("spiking_neuron_array_step_core verification failed");
    end
    $finish;
  end

endmodule

@@ spiking_neuron_array_step_core.f @@
hw/rtl/snas_pkg.sv
hw/rtl/snas_req_if.sv
hw/rtl/snas_rsp_if.sv
hw/rtl/snas_cfg_if.sv
hw/rtl/snas_div.sv
hw/rtl/snas_datapath.sv
hw/rtl/snas_ctrl.sv
hw/rtl/spiking_neuron_array_step_core.sv
tb/spiking_neuron_array_step_core_test.sv
